>>> rtl/core/bpe_pkg.sv
// Shared types and constants for the button debounce to pointer events block.
// Used by bpe_debounce, bpe_report and button_debounce_to_pointer_events.
package bpe_pkg;

    // button count and bit positions in the scan word
    localparam int NUM_BTN    = 11;
    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_LEFT   = 2;
    localparam int BTN_RIGHT  = 3;
    localparam int BTN_LCLICK = 4;
    localparam int BTN_RCLICK = 5;
    localparam int BTN_MCLICK = 6;
    localparam int BTN_SUP    = 7;
    localparam int BTN_SDOWN  = 8;
    localparam int BTN_KEY1   = 9;
    localparam int BTN_KEY2   = 10;

    // one-shot event bits and the button behind each
    localparam int EVT_W = 5;
    localparam int EVENT_BTN [EVT_W] = '{BTN_LCLICK, BTN_RCLICK, BTN_MCLICK, BTN_KEY1, BTN_KEY2};

    // field widths
    localparam int STEP_W  = 7;
    localparam int TIME_W  = 16;
    localparam int DELTA_W = 8;
    localparam int TS_IN_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd3;

    // configuration reset values
    localparam logic [STEP_W-1:0] MOVE_STEP_RST       = 7'd8;
    localparam logic [STEP_W-1:0] SCROLL_STEP_RST     = 7'd1;
    localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RST = 16'd20;
    localparam logic [TIME_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;

    typedef struct packed {
        logic [STEP_W-1:0] move_step;
        logic [STEP_W-1:0] scroll_step;
        logic [TIME_W-1:0] repeat_interval;
        logic [TIME_W-1:0] debounce_time;
    } cfg_t;

    // debounce outcome for one scan
    typedef struct packed {
        logic [NUM_BTN-1:0] stable;
        logic [NUM_BTN-1:0] rearm;
    } deb_t;

    // one result item
    typedef struct packed {
        logic [EVT_W-1:0]          press_events;
        logic                      move_valid;
        logic signed [DELTA_W-1:0] move_dx;
        logic signed [DELTA_W-1:0] move_dy;
        logic                      wheel_valid;
        logic signed [DELTA_W-1:0] wheel_delta;
    } res_t;

endpackage

>>> rtl/core/button_debounce_to_pointer_events.sv
// An accepted item is held in the input register, then its result in the output register.
// Throughput: one item per cycle unless the output stalls, set by the single register pass.
// The output register and the input register each hold one item, so a stalled output
// still lets one more item in.
// Reset: all buttons read released, change times, fired flags and repeat time are zero,
// configuration returns to step 8, scroll 1, repeat 20 ms, debounce 50 ms.
module button_debounce_to_pointer_events #(
    parameter int TIMESTAMP_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [bpe_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [bpe_pkg::NUM_BTN-1:0]            pin_levels,
    input  logic [bpe_pkg::TS_IN_W-1:0]            now_ms,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [bpe_pkg::EVT_W-1:0]              press_events,
    output logic                                   move_valid,
    output logic signed [bpe_pkg::DELTA_W-1:0]     move_dx,
    output logic signed [bpe_pkg::DELTA_W-1:0]     move_dy,
    output logic                                   wheel_valid,
    output logic signed [bpe_pkg::DELTA_W-1:0]     wheel_delta
);
    import bpe_pkg::*;

    localparam int TS_W = TIMESTAMP_BITS;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [NUM_BTN-1:0] pins_reg;
    logic [TS_W-1:0]    now_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               res_reg;
    res_t               res;
    deb_t               deb;
    logic               advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_step       <= MOVE_STEP_RST;
            cfg_reg.scroll_step     <= SCROLL_STEP_RST;
            cfg_reg.repeat_interval <= REPEAT_INTERVAL_RST;
            cfg_reg.debounce_time   <= DEBOUNCE_TIME_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MOVE_STEP:       cfg_reg.move_step       <= cfg_data[STEP_W-1:0];
                CFG_SCROLL_STEP:     cfg_reg.scroll_step     <= cfg_data[STEP_W-1:0];
                CFG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= cfg_data[TIME_W-1:0];
                CFG_DEBOUNCE_TIME:   cfg_reg.debounce_time   <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake control
    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign in_valid_next  = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input item register, timestamp taken modulo the timestamp width
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pins_reg <= pin_levels;
            now_reg  <= TS_W'(now_ms);
        end
    end

    bpe_debounce #(
        .TS_W (TS_W)
    ) u_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .pins          (pins_reg),
        .now           (now_reg),
        .debounce_time (cfg_reg.debounce_time),
        .deb           (deb)
    );

    bpe_report #(
        .TS_W (TS_W)
    ) u_report (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .deb     (deb),
        .now     (now_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign press_events = res_reg.press_events;
    assign move_valid   = res_reg.move_valid;
    assign move_dx      = res_reg.move_dx;
    assign move_dy      = res_reg.move_dy;
    assign wheel_valid  = res_reg.wheel_valid;
    assign wheel_delta  = res_reg.wheel_delta;

endmodule

>>> rtl/core/bpe_debounce.sv
// Per-button debounce lanes: raw level, last change time and stable level.
// Depends on bpe_pkg.
module bpe_debounce #(
    parameter int TS_W = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [bpe_pkg::NUM_BTN-1:0] pins,
    input  logic [TS_W-1:0]             now,
    input  logic [bpe_pkg::TIME_W-1:0]  debounce_time,
    output bpe_pkg::deb_t               deb
);
    import bpe_pkg::*;

    logic [NUM_BTN-1:0] raw_reg;
    logic [NUM_BTN-1:0] stable_reg;
    logic [NUM_BTN-1:0] stable_next;
    logic [NUM_BTN-1:0] settle;
    logic [TS_W-1:0]    change_time_reg  [NUM_BTN];
    logic [TS_W-1:0]    change_time_next [NUM_BTN];
    logic [TS_W-1:0]    elapsed          [NUM_BTN];

    // one lane per button, all in parallel
    for (genvar i = 0; i < NUM_BTN; i++) begin : g_lane
        assign change_time_next[i] = (pins[i] != raw_reg[i]) ? now : change_time_reg[i];
        assign elapsed[i]          = now - change_time_next[i];
        assign settle[i]           = (elapsed[i] > TS_W'(debounce_time))
                                     && (pins[i] != stable_reg[i]);
        assign stable_next[i]      = settle[i] ? pins[i] : stable_reg[i];
    end

    assign deb.stable = stable_next;
    assign deb.rearm  = settle;

    // lane state, released at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= '1;
            stable_reg <= '1;
            for (int i = 0; i < NUM_BTN; i++)
            begin
                change_time_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            raw_reg    <= pins;
            stable_reg <= stable_next;
            for (int i = 0; i < NUM_BTN; i++)
            begin
                change_time_reg[i] <= change_time_next[i];
            end
        end
    end

endmodule

>>> rtl/core/bpe_report.sv
// One-shot press events and hold-repeat pointer and wheel deltas.
// Depends on bpe_pkg; takes the debounced levels from bpe_debounce.
module bpe_report #(
    parameter int TS_W = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  bpe_pkg::deb_t   deb,
    input  logic [TS_W-1:0] now,
    input  bpe_pkg::cfg_t   cfg,
    output bpe_pkg::res_t   res
);
    import bpe_pkg::*;

    logic [NUM_BTN-1:0]        fired_reg;
    logic [NUM_BTN-1:0]        fired_next;
    logic [NUM_BTN-1:0]        held;
    logic [TS_W-1:0]           repeat_time_reg;
    logic [TS_W-1:0]           rep_elapsed;
    logic                      tick;
    logic signed [DELTA_W-1:0] move_amt;
    logic signed [DELTA_W-1:0] wheel_amt;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] wh;

    assign held = ~deb.stable;

    // repeat tick and deltas
    assign rep_elapsed = now - repeat_time_reg;
    assign tick        = rep_elapsed >= TS_W'(cfg.repeat_interval);
    assign move_amt    = {1'b0, cfg.move_step};
    assign wheel_amt   = {1'b0, cfg.scroll_step};

    assign dx = (held[BTN_RIGHT] ? move_amt : '0) - (held[BTN_LEFT] ? move_amt : '0);
    assign dy = (held[BTN_DOWN] ? move_amt : '0) - (held[BTN_UP] ? move_amt : '0);
    assign wh = (held[BTN_SUP] ? wheel_amt : '0) - (held[BTN_SDOWN] ? wheel_amt : '0);

    // one-shot events fire once per stable press, then the repeat outputs
    always_comb
    begin
        fired_next = fired_reg & ~deb.rearm;
        res.press_events = '0;
        for (int k = 0; k < EVT_W; k++)
        begin
            if (held[EVENT_BTN[k]] && !fired_next[EVENT_BTN[k]])
            begin
                fired_next[EVENT_BTN[k]] = 1'b1;
                res.press_events[k]      = 1'b1;
            end
        end
        res.move_valid  = tick && ((dx != '0) || (dy != '0));
        res.move_dx     = res.move_valid ? dx : '0;
        res.move_dy     = res.move_valid ? dy : '0;
        res.wheel_valid = tick && (wh != '0);
        res.wheel_delta = res.wheel_valid ? wh : '0;
    end

    // fired flags and last repeat time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fired_reg       <= '0;
            repeat_time_reg <= '0;
        end
        else if (advance)
        begin
            fired_reg <= fired_next;
            if (tick)
            begin
                repeat_time_reg <= now;
            end
        end
    end

endmodule

>>> sim/button_debounce_to_pointer_events_test.sv
`timescale 1ns / 1ps
// Testbench for button_debounce_to_pointer_events: scans of eleven buttons go in, pointer
// reports come out and are checked against an in-bench debounce and repeat predictor.
// Depends on bpe_pkg and the button_debounce_to_pointer_events RTL only.
module button_debounce_to_pointer_events_test;
    import bpe_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 205;
    localparam int SETTLE_TICKS = 4;

    typedef struct packed {
        logic [NUM_BTN-1:0] pins;
        logic [TS_IN_W-1:0] stamp;
    } scan_t;

    // block ports
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [NUM_BTN-1:0]        pin_levels = '1;
    logic [TS_IN_W-1:0]        now_ms = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [EVT_W-1:0]          press_events;
    logic                      move_valid;
    logic signed [DELTA_W-1:0] move_dx;
    logic signed [DELTA_W-1:0] move_dy;
    logic                      wheel_valid;
    logic signed [DELTA_W-1:0] wheel_delta;

    // predictor copy of the configuration
    logic [STEP_W-1:0] m_move = MOVE_STEP_RST;
    logic [STEP_W-1:0] m_scroll = SCROLL_STEP_RST;
    logic [TIME_W-1:0] m_repeat = REPEAT_INTERVAL_RST;
    logic [TIME_W-1:0] m_debounce = DEBOUNCE_TIME_RST;

    // predictor copy of the button state
    logic [NUM_BTN-1:0] stable_lvl = '1;
    logic [NUM_BTN-1:0] raw_lvl = '1;
    logic [NUM_BTN-1:0] fired = '0;
    logic [TS_IN_W-1:0] chg_time [NUM_BTN] = '{default: '0};
    logic [TS_IN_W-1:0] rpt_time = '0;

    // pending scans and expected reports
    scan_t scan_q [$];
    res_t  report_q [$];
    scan_t next_scan;
    res_t  want;

    // stimulus generator state
    logic [TS_IN_W-1:0] stamp_now = '0;
    logic [NUM_BTN-1:0] hold_pat = '1;

    int send_idle_pct = 18;
    int recv_idle_pct = 78;
    int errors = 0;
    int cycle_cnt = 0;

    // long receiver hold-off
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;
    logic hold_on;
    assign hold_on = hold_arm && !hold_done;

    button_debounce_to_pointer_events dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_levels   (pin_levels),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .press_events (press_events),
        .move_valid   (move_valid),
        .move_dx      (move_dx),
        .move_dy      (move_dy),
        .wheel_valid  (wheel_valid),
        .wheel_delta  (wheel_delta)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // debounce one scan, fire one-shots, then run the repeat tick
    function automatic res_t predict_pointer_report(logic [NUM_BTN-1:0] pins,
                                                    logic [TS_IN_W-1:0] now);
        res_t r;
        int   i;
        int   dx;
        int   dy;
        int   wh;
        r = '0;
        for (i = 0; i < NUM_BTN; i++)
        begin
            if (pins[i] != raw_lvl[i])
            begin
                raw_lvl[i] = pins[i];
                chg_time[i] = now;
            end
            if (now - chg_time[i] > {16'd0, m_debounce} && pins[i] != stable_lvl[i])
            begin
                stable_lvl[i] = pins[i];
                fired[i] = 1'b0;
            end
        end
        for (i = 0; i < EVT_W; i++)
        begin
            if (!stable_lvl[EVENT_BTN[i]] && !fired[EVENT_BTN[i]])
            begin
                fired[EVENT_BTN[i]] = 1'b1;
                r.press_events[i] = 1'b1;
            end
        end
        if (now - rpt_time >= {16'd0, m_repeat})
        begin
            dx = 0;
            dy = 0;
            wh = 0;
            if (!stable_lvl[BTN_LEFT])  dx -= m_move;
            if (!stable_lvl[BTN_RIGHT]) dx += m_move;
            if (!stable_lvl[BTN_UP])    dy -= m_move;
            if (!stable_lvl[BTN_DOWN])  dy += m_move;
            if (!stable_lvl[BTN_SUP])   wh += m_scroll;
            if (!stable_lvl[BTN_SDOWN]) wh -= m_scroll;
            // opposite directions cancel to no move at all
            if (dx != 0 || dy != 0)
            begin
                r.move_valid = 1'b1;
                r.move_dx = dx[DELTA_W-1:0];
                r.move_dy = dy[DELTA_W-1:0];
            end
            if (wh != 0)
            begin
                r.wheel_valid = 1'b1;
                r.wheel_delta = wh[DELTA_W-1:0];
            end
            rpt_time = now;
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", fname, want_v, got_v);
            errors++;
        end
    endtask

    // scan driver: predict on acceptance, then offer the next pending item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                report_q.push_back(predict_pointer_report(pin_levels, now_ms));
            if (!in_valid || in_ready)
            begin
                if (scan_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_scan = scan_q.pop_front();
                    in_valid <= 1'b1;
                    pin_levels <= next_scan.pins;
                    now_ms <= next_scan.stamp;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // report monitor and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report item with no scan outstanding");
                    errors++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("press_events", want.press_events, press_events);
                    check_field("move_valid", want.move_valid, move_valid);
                    check_field("move_dx", want.move_dx, move_dx);
                    check_field("move_dy", want.move_dy, move_dy);
                    check_field("wheel_valid", want.wheel_valid, wheel_valid);
                    check_field("wheel_delta", want.wheel_delta, wheel_delta);
                end
            end
            out_ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // hold-off counter
    always @(posedge clk)
    begin
        if (hold_on)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("button_debounce_to_pointer_events_test: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MOVE_STEP:       m_move = val[STEP_W-1:0];
            CFG_SCROLL_STEP:     m_scroll = val[STEP_W-1:0];
            CFG_REPEAT_INTERVAL: m_repeat = val[TIME_W-1:0];
            CFG_DEBOUNCE_TIME:   m_debounce = val[TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] mv, input logic [CFG_DATA_W-1:0] sc,
                              input logic [CFG_DATA_W-1:0] rp, input logic [CFG_DATA_W-1:0] db);
        write_reg(CFG_MOVE_STEP, mv);
        write_reg(CFG_SCROLL_STEP, sc);
        write_reg(CFG_REPEAT_INTERVAL, rp);
        write_reg(CFG_DEBOUNCE_TIME, db);
    endtask

    task automatic add_scan(input logic [NUM_BTN-1:0] pins, input logic [TS_IN_W-1:0] stamp);
        scan_t s;
        s.pins = pins;
        s.stamp = stamp;
        scan_q.push_back(s);
    endtask

    // wait until every item is accepted and every report is back
    task automatic drain();
        while (scan_q.size() != 0 || in_valid || report_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    // held patterns with bounces and boundary time steps, plus some raw noise
    task automatic queue_phase(input int n_items);
        scan_t s;
        int    k;
        int    span;
        span = (m_debounce + m_repeat) / 4 + 2;
        for (k = 0; k < n_items; k++)
        begin
            if ($urandom_range(99) < 8)
            begin
                s.pins = NUM_BTN'($urandom());
                s.stamp = $urandom();
            end
            else
            begin
                if ($urandom_range(99) < 15)
                begin
                    case ($urandom_range(3))
                        0: hold_pat = NUM_BTN'($urandom());
                        1: hold_pat ^= 11'd1 << $urandom_range(NUM_BTN - 1);
                        2: hold_pat = '1;
                        default: hold_pat = ~(11'd1 << $urandom_range(NUM_BTN - 1));
                    endcase
                end
                case ($urandom_range(19))
                    0, 1: stamp_now += m_debounce + $urandom_range(0, 1);
                    2: stamp_now += m_repeat;
                    default: stamp_now += $urandom_range(0, span);
                endcase
                s.pins = hold_pat;
                // single-scan contact bounce
                if ($urandom_range(99) < 10)
                    s.pins ^= 11'd1 << $urandom_range(NUM_BTN - 1);
                s.stamp = stamp_now;
            end
            scan_q.push_back(s);
        end
    endtask

    initial
    begin
        int p;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: debounce edge, one-shots, repeat edge, cancel, wrap
        add_scan(11'h7FF, 32'd0);
        add_scan(11'h000, 32'd10);
        add_scan(11'h000, 32'd60);
        add_scan(11'h000, 32'd61);
        add_scan(11'h10A, 32'd62);
        add_scan(11'h10A, 32'd120);
        add_scan(11'h10A, 32'd139);
        add_scan(11'h10A, 32'd140);
        add_scan(11'h085, 32'd141);
        add_scan(11'h085, 32'd192);
        add_scan(11'h7FF, 32'd200);
        add_scan(11'h000, 32'd210);
        add_scan(11'h7FF, 32'd215);
        add_scan(11'h7FF, 32'd266);
        add_scan(11'h7EF, 32'd300);
        add_scan(11'h7EF, 32'd351);
        add_scan(11'h7FF, 32'hFFFF_FFF0);
        add_scan(11'h7FF, 32'hFFFF_FFFF);
        add_scan(11'h7FF, 32'h0000_0023);
        add_scan(11'h7FF, 32'h0000_0024);
        drain();

        // random part, timestamps start just below the wrap
        stamp_now = 32'hFFFF_FF00;
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: set_config(16'hFFFF, 16'h007F, 16'd0, 16'd0);
                1: set_config(16'hFF80, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_config(CFG_DATA_W'($urandom_range(0, 65535)),
                                    CFG_DATA_W'($urandom_range(0, 65535)),
                                    CFG_DATA_W'($urandom_range(0, 60)),
                                    CFG_DATA_W'($urandom_range(0, 80)));
            endcase
            if (p >= 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (p >= 2)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 18;
            end
            queue_phase(PHASE_ITEMS);
            // stall the output while scans keep coming
            if (p == 4)
                hold_arm = 1'b1;
            drain();
        end

        if (errors == 0)
            $display("button_debounce_to_pointer_events_test: PASS");
        else
            $display("button_debounce_to_pointer_events_test: FAIL");
        $finish;
    end

endmodule
